/* sv/assert_macros.svh */
// Assertion macros for the checker file of this block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define IOL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define IOL_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* sv/iol_pkg.sv */
// Package for the indexed ordered list: action and status codes,
// fixed port widths and parameter defaults. No dependencies.
`default_nettype none

package iol_pkg;

	// Widths of the item and result fields.
	localparam int ACT_W = 3;
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int CNT_W = 7;

	// Parameter defaults for the top level.
	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_READ     = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CONTAINS = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd5;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

/* sv/indexed_ordered_list_top.sv */
// Indexed ordered list: the entries live in one synchronous memory that is
// shifted one entry per cycle. Depends on iol_pkg.
//
// Usage. An item (action, position, item_value) is accepted at a rising edge
// with start high and busy low. Each item gives exactly one result, shown on
// result_value, found, status and entry_count for one cycle while done is high.
// The receiver cannot stall, so a result is simply dropped if not taken.
//
// How each item is handled after the accepting edge:
//   append, clear, unused codes and every failed request: done is set by that edge.
//   read: the entry is read at that edge, then captured into the result.
//   remove at p: the entry at p is captured and the entries above it shift down.
//   insert at p < count: entries from p shift up, then the new value is written at p (insert at count acts as append).
//   contains: the whole list is always scanned.
// busy stays low in the cycle done is high, so the next item may be accepted
// there. The cost is set by the single memory port pair: one entry is read per
// cycle while entries are shifted or scanned; a shift also writes one back.
//
// Reset clears the entry count and the control state at once; no clearing pass
// is run, since an entry at or above the count is never read.
`default_nettype none

module indexed_ordered_list_top #(
	parameter int CAPACITY   = iol_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = iol_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [iol_pkg::ACT_W-1:0] action,
	input  wire logic [iol_pkg::POS_W-1:0] position,
	input  wire logic [iol_pkg::VAL_W-1:0] item_value,
	output logic                           done,
	output logic [iol_pkg::VAL_W-1:0]      result_value,
	output logic                           found,
	output logic [iol_pkg::ST_W-1:0]       status,
	output logic [iol_pkg::CNT_W-1:0]      entry_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > iol_pkg::POS_W) ? CW : iol_pkg::POS_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WORK = 2'b10
	} state_t;

	// Entry storage and its registered read data.
	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rdata_q;

	// Control registers.
	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] left_q;
	logic          pend_q;
	logic          cap_q;
	logic          done_q;

	// Item and result registers.
	logic [iol_pkg::ACT_W-1:0] op_q;
	logic [AW-1:0]             pos_q;
	logic [DATA_WIDTH-1:0]     val_q;
	logic [AW-1:0]             a_q;
	logic [AW-1:0]             pend_addr_q;
	logic [iol_pkg::VAL_W-1:0] res_value_q;
	logic                      found_q;
	logic [iol_pkg::ST_W-1:0]  status_q;

	// Memory port controls.
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;

	logic                     accept;
	logic                     full;
	logic [XW-1:0]            pos_x;
	logic [XW-1:0]            cnt_x;
	logic [AW-1:0]            pos_a;
	logic [DATA_WIDTH-1:0]    val_dw;
	logic                     match;
	logic                     finish;
	logic [iol_pkg::ST_W-1:0] acc_status;

	assign accept = start && (state_q == ST_IDLE);
	assign full   = (count_q == CW'(CAPACITY));
	assign pos_x  = XW'(position);
	assign cnt_x  = XW'(count_q);
	assign pos_a  = AW'(position);
	assign val_dw = DATA_WIDTH'(item_value);
	assign match  = pend_q && (rdata_q == val_q);

	// The walk ends once all reads are issued; an insert first drains its last
	// shifted write so the new value can take the write port.
	assign finish = (state_q == ST_WORK) && (left_q == '0)
		&& !((op_q == iol_pkg::ACT_INSERT) && pend_q);

	// Status of an item decided at the accepting edge.
	always_comb begin
		acc_status = iol_pkg::ST_OK;
		case (action)
			iol_pkg::ACT_APPEND: begin
				if (full) acc_status = iol_pkg::ST_FULL;
			end
			iol_pkg::ACT_INSERT: begin
				if (pos_x > cnt_x) acc_status = iol_pkg::ST_RANGE;
				else if (full) acc_status = iol_pkg::ST_FULL;
			end
			iol_pkg::ACT_REMOVE, iol_pkg::ACT_READ: begin
				if (pos_x >= cnt_x) acc_status = iol_pkg::ST_RANGE;
			end
			default: acc_status = iol_pkg::ST_OK;
		endcase
	end

	// Memory port selection: direct access at accept, walk accesses afterward.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = a_q;
		wr_en   = 1'b0;
		wr_addr = pend_addr_q;
		wr_data = rdata_q;
		if (accept) begin
			if (((action == iol_pkg::ACT_REMOVE) || (action == iol_pkg::ACT_READ))
				&& (pos_x < cnt_x)) begin
				rd_en   = 1'b1;
				rd_addr = pos_a;
			end
			if (((action == iol_pkg::ACT_APPEND)
				|| ((action == iol_pkg::ACT_INSERT) && (pos_x == cnt_x))) && !full) begin
				wr_en   = 1'b1;
				wr_addr = AW'(count_q);
				wr_data = val_dw;
			end
		end
		if (state_q == ST_WORK) begin
			if (left_q != '0) rd_en = 1'b1;
			if (pend_q && ((op_q == iol_pkg::ACT_INSERT) || (op_q == iol_pkg::ACT_REMOVE))) begin
				wr_en = 1'b1;
			end else if (finish && (op_q == iol_pkg::ACT_INSERT)) begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = val_q;
			end
		end
	end

	// Synchronous memory with one write and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	// Sequencer and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			left_q  <= '0;
			pend_q  <= 1'b0;
			cap_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				pend_q <= 1'b0;
				case (action)
					iol_pkg::ACT_APPEND: begin
						if (!full) count_q <= CW'(count_q + 1'b1);
						done_q <= 1'b1;
					end
					iol_pkg::ACT_INSERT: begin
						if (acc_status != iol_pkg::ST_OK) begin
							done_q <= 1'b1;
						end else if (pos_x == cnt_x) begin
							count_q <= CW'(count_q + 1'b1);
							done_q  <= 1'b1;
						end else begin
							left_q  <= CW'(cnt_x - pos_x);
							state_q <= ST_WORK;
						end
					end
					iol_pkg::ACT_REMOVE, iol_pkg::ACT_READ: begin
						if (acc_status != iol_pkg::ST_OK) begin
							done_q <= 1'b1;
						end else begin
							cap_q   <= 1'b1;
							left_q  <= (action == iol_pkg::ACT_REMOVE)
								? CW'(cnt_x - pos_x - 1'b1) : '0;
							state_q <= ST_WORK;
						end
					end
					iol_pkg::ACT_CONTAINS: begin
						left_q  <= count_q;
						state_q <= ST_WORK;
					end
					iol_pkg::ACT_CLEAR: begin
						count_q <= '0;
						done_q  <= 1'b1;
					end
					default: done_q <= 1'b1;
				endcase
			end
			if (state_q == ST_WORK) begin
				cap_q  <= 1'b0;
				pend_q <= (left_q != '0);
				if (left_q != '0) left_q <= CW'(left_q - 1'b1);
				if (finish) begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					if (op_q == iol_pkg::ACT_INSERT) count_q <= CW'(count_q + 1'b1);
					else if (op_q == iol_pkg::ACT_REMOVE) count_q <= CW'(count_q - 1'b1);
				end
			end
		end
	end

	// Item fields, walk addresses and result fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= action;
			pos_q       <= pos_a;
			val_q       <= val_dw;
			res_value_q <= '0;
			found_q     <= 1'b0;
			status_q    <= acc_status;
			case (action)
				iol_pkg::ACT_INSERT: a_q <= AW'(count_q - 1'b1);
				iol_pkg::ACT_REMOVE: a_q <= AW'(pos_x + 1'b1);
				default:             a_q <= '0;
			endcase
		end
		if (state_q == ST_WORK) begin
			if (left_q != '0) begin
				if (op_q == iol_pkg::ACT_INSERT) begin
					a_q         <= AW'(a_q - 1'b1);
					pend_addr_q <= AW'(a_q + 1'b1);
				end else begin
					a_q         <= AW'(a_q + 1'b1);
					pend_addr_q <= AW'(a_q - 1'b1);
				end
			end
			if (cap_q) res_value_q <= iol_pkg::VAL_W'(rdata_q);
			if ((op_q == iol_pkg::ACT_CONTAINS) && match) found_q <= 1'b1;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign result_value = res_value_q;
	assign found        = found_q;
	assign status       = status_q;
	assign entry_count  = iol_pkg::CNT_W'(count_q);

endmodule

`default_nettype wire

/* sv/iol_checker.sv */
// Port-level checker for the indexed ordered list, bound to the top level.
// Depends on iol_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module iol_checker #(
	parameter int CAPACITY = iol_pkg::CAPACITY_DEF
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic [iol_pkg::ACT_W-1:0] action,
	input wire logic                      done,
	input wire logic                      found,
	input wire logic [iol_pkg::ST_W-1:0]  status,
	input wire logic [iol_pkg::CNT_W-1:0] entry_count
);

	// A result is only shown once the walk is over.
	`IOL_ASSERT(a_done_idle, done |-> !busy, "result shown while still busy")

	// Only the three defined status codes appear.
	`IOL_ASSERT_NEVER(a_status_code, done && (status != iol_pkg::ST_OK) && (status != iol_pkg::ST_RANGE) && (status != iol_pkg::ST_FULL), "undefined status code")

	// A full store reports its whole capacity.
	`IOL_ASSERT(a_full_count, (done && (status == iol_pkg::ST_FULL)) |-> (entry_count == iol_pkg::CNT_W'(CAPACITY)), "full status with wrong count")

	// A match is only reported with ok status.
	`IOL_ASSERT(a_found_ok, (done && found) |-> (status == iol_pkg::ST_OK), "found with failing status")

	// Clear answers in the next cycle with an empty list.
	`IOL_ASSERT(a_clear, (start && !busy && (action == iol_pkg::ACT_CLEAR)) |=> (done && (entry_count == '0) && (status == iol_pkg::ST_OK)), "clear did not empty the list")

endmodule

bind indexed_ordered_list_top iol_checker #(.CAPACITY(CAPACITY)) u_iol_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.action      (action),
	.done        (done),
	.found       (found),
	.status      (status),
	.entry_count (entry_count)
);

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for indexed_ordered_list_top: directed and random list requests,
// each result checked field by field against a behavioral list kept in the bench.
// Depends on iol_pkg and indexed_ordered_list_top.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iol_pkg::*;

	localparam int CAPACITY     = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1700;
	localparam int END_WAIT     = 200;
	localparam int DRAIN_CYCLES = 100;
	localparam int LIMIT_NS     = 5_000_000;

	// Action codes the block treats as no operation.
	localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] item_value;
	} list_req_t;

	typedef struct packed {
		logic [VAL_W-1:0] result_value;
		logic             found;
		logic [ST_W-1:0]  status;
		logic [CNT_W-1:0] entry_count;
	} list_reply_t;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [ACT_W-1:0] action = '0;
	logic [POS_W-1:0] position = '0;
	logic [VAL_W-1:0] item_value = '0;
	logic             busy;
	logic             done;
	logic [VAL_W-1:0] result_value;
	logic             found;
	logic [ST_W-1:0]  status;
	logic [CNT_W-1:0] entry_count;

	// Pending requests, predicted replies and the bench's own copy of the list.
	list_req_t        pending_reqs[$];
	list_reply_t      expected_replies[$];
	logic [VAL_W-1:0] model_vals [CAPACITY];
	int               model_len = 0;
	int               plan_len = 0;
	int               issued_total = 0;
	int               accepted_total = 0;
	int               error_count = 0;
	int               gap_left = 0;
	int               burst_left = 1;

	indexed_ordered_list_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.position    (position),
		.item_value  (item_value),
		.done        (done),
		.result_value(result_value),
		.found       (found),
		.status      (status),
		.entry_count (entry_count)
	);

	always #5 clk = ~clk;

	// Apply one request to the bench's list and work out the reply it gives.
	task automatic apply_list_op(input list_req_t req, output list_reply_t rep);
		int p;
		int i;
		p = req.position;
		rep = '0;
		rep.status = ST_OK;
		case (req.action)
			ACT_APPEND: begin
				if (model_len >= CAPACITY) begin
					rep.status = ST_FULL;
				end else begin
					model_vals[model_len] = req.item_value;
					model_len++;
				end
			end
			ACT_INSERT: begin
				if (p > model_len) begin
					rep.status = ST_RANGE;
				end else if (model_len >= CAPACITY) begin
					rep.status = ST_FULL;
				end else begin
					for (i = model_len; i > p; i--)
						model_vals[i] = model_vals[i-1];
					model_vals[p] = req.item_value;
					model_len++;
				end
			end
			ACT_REMOVE: begin
				if (p >= model_len) begin
					rep.status = ST_RANGE;
				end else begin
					rep.result_value = model_vals[p];
					for (i = p; i + 1 < model_len; i++)
						model_vals[i] = model_vals[i+1];
					model_len--;
				end
			end
			ACT_READ: begin
				if (p >= model_len)
					rep.status = ST_RANGE;
				else
					rep.result_value = model_vals[p];
			end
			ACT_CONTAINS: begin
				for (i = 0; i < model_len; i++)
					if (model_vals[i] == req.item_value)
						rep.found = 1'b1;
			end
			ACT_CLEAR: begin
				model_len = 0;
			end
			default: ;
		endcase
		rep.entry_count = CNT_W'(model_len);
	endtask

	// Queue a request and track the list length it leaves, to aim later positions.
	task automatic plan_request(input logic [ACT_W-1:0] act, input int pos,
			input logic [VAL_W-1:0] val);
		list_req_t req;
		req.action = act;
		req.position = POS_W'(pos);
		req.item_value = val;
		pending_reqs.push_back(req);
		case (act)
			ACT_APPEND: if (plan_len < CAPACITY) plan_len++;
			ACT_INSERT: if (pos <= plan_len && plan_len < CAPACITY) plan_len++;
			ACT_REMOVE: if (pos < plan_len) plan_len--;
			ACT_CLEAR:  plan_len = 0;
			default: ;
		endcase
	endtask

	// Mostly legal positions, with the range edges and wild values mixed in.
	function automatic int pick_position(input bit for_insert);
		int r;
		int top;
		r = $urandom_range(99);
		top = for_insert ? plan_len : plan_len - 1;
		if (r < 75 && top >= 0)
			return $urandom_range(top, 0);
		if (r < 85)
			return plan_len;
		if (r < 92)
			return plan_len + 1;
		return $urandom_range(127, 0);
	endfunction

	// Values from a small pool so that membership tests hit, plus full-range values.
	function automatic logic [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return VAL_W'($urandom_range(15, 0));
		if (r < 45)
			return '1;
		if (r < 48)
			return '0;
		return $urandom;
	endfunction

	// Driver: holds an item until it is taken, then sends the next one in bursts with gaps.
	always @(negedge clk) begin : drive
		list_req_t req;
		logic      raise;
		raise = start;
		if (arst_n) begin
			if (!start || accepted_total == issued_total) begin
				raise = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() != 0) begin
					req = pending_reqs.pop_front();
					action <= req.action;
					position <= req.position;
					item_value <= req.item_value;
					issued_total++;
					raise = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(4) == 0) ? $urandom_range(300, 100)
							: $urandom_range(30, 1);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
					end
				end
			end
		end
		start <= raise;
	end

	// Monitor: checks each result, then predicts the reply of any item taken at this edge.
	always @(posedge clk) begin : watch
		list_reply_t want;
		list_reply_t got;
		list_req_t   req;
		if (arst_n) begin
			if (done) begin
				got.result_value = result_value;
				got.found = found;
				got.status = status;
				got.entry_count = entry_count;
				if (expected_replies.size() == 0) begin
					$error("result with no item waiting for it");
					error_count++;
				end else begin
					want = expected_replies.pop_front();
					if (got.result_value !== want.result_value) begin
						$error("result_value: expected %h, got %h", want.result_value,
							got.result_value);
						error_count++;
					end
					if (got.found !== want.found) begin
						$error("found: expected %b, got %b", want.found, got.found);
						error_count++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						error_count++;
					end
					if (got.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want.entry_count,
							got.entry_count);
						error_count++;
					end
				end
			end
			if (start && !busy) begin
				req.action = action;
				req.position = position;
				req.item_value = item_value;
				accepted_total++;
				apply_list_op(req, want);
				expected_replies.push_back(want);
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		traffic_mode_t    mode;
		int               mode_left;
		int               n;
		int               r;
		int               pos;
		int               wait_cycles;
		bit               noise;
		logic [ACT_W-1:0] act;
		logic [VAL_W-1:0] val;

		// Directed: empty list, both ends, middle, range edges, spare codes, clear.
		plan_request(ACT_READ, 0, '0);
		plan_request(ACT_REMOVE, 0, '0);
		plan_request(ACT_CONTAINS, 0, '0);
		plan_request(ACT_INSERT, 1, 32'h0000_0001);
		plan_request(ACT_INSERT, 0, 32'hFFFF_FFFF);
		plan_request(ACT_APPEND, 0, 32'h0000_0000);
		plan_request(ACT_APPEND, 0, 32'hA5A5_A5A5);
		plan_request(ACT_INSERT, 1, 32'h5A5A_5A5A);
		plan_request(ACT_INSERT, 127, 32'h1234_5678);
		plan_request(ACT_INSERT, 0, 32'h8000_0001);
		plan_request(ACT_READ, 0, '0);
		plan_request(ACT_READ, 4, '0);
		plan_request(ACT_READ, 5, '0);
		plan_request(ACT_CONTAINS, 0, 32'h8000_0001);
		plan_request(ACT_CONTAINS, 0, 32'hA5A5_A5A5);
		plan_request(ACT_CONTAINS, 0, 32'h1234_5678);
		plan_request(ACT_REMOVE, 4, '0);
		plan_request(ACT_REMOVE, 0, '0);
		plan_request(ACT_REMOVE, 64, '0);
		plan_request(ACT_SPARE_A, 0, '0);
		plan_request(ACT_SPARE_B, 127, '1);
		plan_request(ACT_CLEAR, 0, '0);
		plan_request(ACT_READ, 0, '0);

		// Random: traffic phases that fill, drain or mix; the first one fills to full.
		mode = MODE_FILL;
		mode_left = 110;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (mode_left == 0) begin
				mode = traffic_mode_t'($urandom_range(2, 0));
				mode_left = $urandom_range(120, 20);
			end
			mode_left--;
			r = $urandom_range(99);
			noise = 1'b0;
			case (mode)
				MODE_FILL: begin
					if (r < 45)      act = ACT_APPEND;
					else if (r < 80) act = ACT_INSERT;
					else if (r < 88) act = ACT_READ;
					else if (r < 96) act = ACT_CONTAINS;
					else             act = ACT_REMOVE;
				end
				MODE_DRAIN: begin
					if (r < 50)      act = ACT_REMOVE;
					else if (r < 65) act = ACT_READ;
					else if (r < 80) act = ACT_CONTAINS;
					else if (r < 90) act = ACT_INSERT;
					else if (r < 98) act = ACT_APPEND;
					else             act = ACT_CLEAR;
				end
				default: begin
					if (r < 20)      act = ACT_APPEND;
					else if (r < 40) act = ACT_INSERT;
					else if (r < 60) act = ACT_REMOVE;
					else if (r < 75) act = ACT_READ;
					else if (r < 90) act = ACT_CONTAINS;
					else if (r < 93) act = ACT_CLEAR;
					else if (r < 95) act = ($urandom_range(1) != 0) ? ACT_SPARE_A : ACT_SPARE_B;
					else begin
						act = ACT_W'($urandom_range(7, 0));
						noise = 1'b1;
					end
				end
			endcase
			if (noise) begin
				pos = $urandom_range(127, 0);
				val = $urandom;
			end else begin
				pos = pick_position(act == ACT_INSERT);
				if (act == ACT_CONTAINS && $urandom_range(9) < 6)
					val = VAL_W'($urandom_range(15, 0));
				else
					val = pick_value();
			end
			plan_request(act, pos, val);
		end

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Wait for every item to be taken and every result to arrive.
		while (pending_reqs.size() != 0 || accepted_total != issued_total)
			@(posedge clk);
		wait_cycles = 0;
		while (expected_replies.size() != 0 && wait_cycles < END_WAIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_replies.size() != 0) begin
			$error("%0d results never arrived", expected_replies.size());
			error_count++;
		end

		if (error_count == 0)
			$display("** indexed_ordered_list_top: PASSED **");
		else
			$display("** indexed_ordered_list_top: FAILED **");
		$finish;
	end

	// Hang guard.
	initial begin : watchdog
		#(LIMIT_NS);
		$display("** indexed_ordered_list_top: FAILED **");
		$finish;
	end

endmodule

/* indexed_ordered_list_top.f */
+incdir+sv
sv/iol_pkg.sv
sv/indexed_ordered_list_top.sv
sv/iol_checker.sv
test/tb.sv
